// ===== hw/rtl/rrts_pkg.sv =====
// Package for the round-robin thread scheduler: slot states, operation codes,
// register indexes, controller states and the command/status structs. No dependencies.
`default_nettype none
package rrts_pkg;
  localparam int SlotCountDef = 16;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_YIELD  = 3'd1,
    OP_CREATE = 3'd2,
    OP_KILL   = 3'd3,
    OP_SLEEP  = 3'd4
  } op_t;

  localparam logic CFG_SLICE  = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN_FREE,
    CS_PREP,
    CS_WAKE,
    CS_PICK,
    CS_DONE
  } ctl_state_t;

  typedef struct packed {
    logic latch;       // capture the input word and run the immediate part
    logic scan_init;   // clear scan index
    logic scan_step;   // advance scan index
    logic create_step; // test scan slot for free, take it if so
    logic prep;        // save pointer, demote running current
    logic wake_step;   // wake scan slot if due
    logic pick_step;   // test candidate slot for ready
    logic finish;      // commit pick
    logic emit;        // drive result strobe
    logic set_sw;      // result marks a switch
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;       // create found a slot / pick found a ready slot
    logic need_switch;
    logic is_create;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/round_robin_thread_scheduler_core.sv =====
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
// Usage:
//   Raise start with in_operation, in_thread_slot, in_stack_pointer and
//   in_sleep_ticks while busy is low; the word is taken on that edge.
//   busy stays high until the result word is shown.
//   The result word appears for one cycle with out_valid high; the receiver
//   cannot stall it and must take it then.
//   Steps: an item with no switch goes straight to the result; create first
//   scans up to SLOT_COUNT slots for a free one; a switch saves the pointer
//   and demotes the running slot, runs a wake scan over all slots, then
//   searches for a ready slot from the one after the current. One item at a
//   time; a new word is taken only once busy is low again.
//   cfg_we writes slice_length (index 0) or scheduler_enabled (index 1);
//   the user must write only while idle; the block does not enforce it.
//   Synchronous reset: slot 0 running with id 1, others dead, time zero,
//   slice length 10, scheduling disabled.
`default_nettype none
module round_robin_thread_scheduler_core #(
  parameter int SLOT_COUNT = rrts_pkg::SlotCountDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [3:0]  in_thread_slot,
  input  wire logic [63:0] in_stack_pointer,
  input  wire logic [31:0] in_sleep_ticks,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  output logic             out_switched,
  output logic [3:0]       out_running_slot,
  output logic [63:0]      out_resume_pointer,
  output logic [31:0]      out_thread_id,
  output logic             out_status
);
  rrts_pkg::dp_cmd_t cmd;
  rrts_pkg::dp_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  rrts_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_operation(in_operation), .in_thread_slot(in_thread_slot),
    .in_stack_pointer(in_stack_pointer), .in_sleep_ticks(in_sleep_ticks),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_switched(out_switched),
    .out_running_slot(out_running_slot), .out_resume_pointer(out_resume_pointer),
    .out_thread_id(out_thread_id), .out_status(out_status)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/rrts_ctrl.sv =====
// Controller for the round-robin thread scheduler.
// Depends on rrts_pkg.
`default_nettype none
module rrts_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire rrts_pkg::dp_sts_t sts,
  output rrts_pkg::dp_cmd_t   cmd
);
  rrts_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rrts_pkg::CS_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != rrts_pkg::CS_IDLE);
    case (state_r)
      rrts_pkg::CS_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt = rrts_pkg::CS_DONE;
          if (sts.is_create) state_nxt = rrts_pkg::CS_SCAN_FREE;
          else if (sts.need_switch) state_nxt = rrts_pkg::CS_PREP;
        end
      end
      rrts_pkg::CS_SCAN_FREE: begin
        cmd.create_step = 1'b1;
        cmd.scan_step = 1'b1;
        if (sts.found || sts.scan_last) state_nxt = rrts_pkg::CS_DONE;
      end
      rrts_pkg::CS_PREP: begin
        cmd.prep = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = rrts_pkg::CS_WAKE;
      end
      rrts_pkg::CS_WAKE: begin
        cmd.wake_step = 1'b1;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.scan_init = 1'b1;
          cmd.scan_step = 1'b0;
          state_nxt = rrts_pkg::CS_PICK;
        end
      end
      rrts_pkg::CS_PICK: begin
        cmd.pick_step = 1'b1;
        cmd.scan_step = 1'b1;
        if (sts.found || sts.scan_last) begin
          cmd.finish = 1'b1;
          cmd.set_sw = 1'b1;
          state_nxt = rrts_pkg::CS_DONE;
        end
      end
      rrts_pkg::CS_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = rrts_pkg::CS_IDLE;
      end
      default: state_nxt = rrts_pkg::CS_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rrts_dp.sv =====
// Datapath for the round-robin thread scheduler: slot table, time and slice
// counters, scan index and result registers. Depends on rrts_pkg.
`default_nettype none
module rrts_dp #(
  parameter int SLOT_COUNT = rrts_pkg::SlotCountDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [2:0]   in_operation,
  input  wire logic [3:0]   in_thread_slot,
  input  wire logic [63:0]  in_stack_pointer,
  input  wire logic [31:0]  in_sleep_ticks,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_data,
  input  wire rrts_pkg::dp_cmd_t cmd,
  output rrts_pkg::dp_sts_t sts,
  output logic              out_valid,
  output logic              out_switched,
  output logic [3:0]        out_running_slot,
  output logic [63:0]       out_resume_pointer,
  output logic [31:0]       out_thread_id,
  output logic              out_status
);
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  rrts_pkg::slot_state_t st_r [SLOT_COUNT];
  logic [31:0] id_r   [SLOT_COUNT];
  logic [63:0] sp_r   [SLOT_COUNT];
  logic [63:0] wake_r [SLOT_COUNT];
  logic [SW-1:0] cur_r, idx_r, cand;
  logic [CW-1:0] cnt_r;
  logic [7:0]  slice_cnt_r, slice_len_r;
  logic        en_r;
  logic [31:0] next_id_r, next_id_inc;
  logic [63:0] now_r;
  logic [63:0] sp_in_r;

  logic        sw_need, slot_ok, live, slice_hit, lat_status;
  logic [SW-1:0] tslot;
  logic [7:0]  slice_inc;
  logic [SW:0] cand_sum;
  rrts_pkg::op_t op;

  assign op = rrts_pkg::op_t'(in_operation);
  assign tslot = SW'(in_thread_slot);
  assign slot_ok = ({{(SW+5){1'b0}}, in_thread_slot} < (SW + 9)'(SLOT_COUNT));
  assign live = slot_ok && st_r[tslot] != rrts_pkg::ST_DEAD && id_r[tslot] != '0;
  assign slice_inc = (slice_cnt_r != 8'hFF) ? slice_cnt_r + 8'd1 : slice_cnt_r;
  assign slice_hit = slice_inc >= slice_len_r;
  always_comb begin
    sw_need = 1'b0;
    case (op)
      rrts_pkg::OP_TICK:  sw_need = en_r && slice_hit;
      rrts_pkg::OP_YIELD, rrts_pkg::OP_KILL, rrts_pkg::OP_SLEEP: sw_need = en_r;
      default:            sw_need = 1'b0;
    endcase
  end

  // status captured with the input word
  always_comb begin
    case (op)
      rrts_pkg::OP_CREATE: lat_status = 1'b1;
      rrts_pkg::OP_KILL:   lat_status = !live;
      rrts_pkg::OP_SLEEP:  lat_status = en_r && !live;
      default:             lat_status = 1'b0;
    endcase
  end

  assign cand_sum = {1'b0, cur_r} + {1'b0, idx_r} + 1'b1;
  assign cand = ((SW+1)'(cand_sum) >= (SW+1)'(SLOT_COUNT)) ?
                SW'(cand_sum - (SW+1)'(SLOT_COUNT)) : SW'(cand_sum);
  assign next_id_inc = (next_id_r + 32'd1 == 32'd0) ? 32'd1 : next_id_r + 32'd1;

  always_comb begin
    sts = '0;
    sts.scan_last = (cnt_r == CW'(SLOT_COUNT - 1));
    sts.need_switch = sw_need;
    sts.is_create = (op == rrts_pkg::OP_CREATE);
    if (cmd.create_step)
      sts.found = st_r[idx_r] == rrts_pkg::ST_DEAD && id_r[idx_r] == '0;
    else if (cmd.pick_step)
      sts.found = st_r[cand] == rrts_pkg::ST_READY;
  end

  // slot table, counters and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st_r[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_DEAD;
        id_r[i] <= (i == 0) ? 32'd1 : 32'd0;
        sp_r[i] <= '0;
        wake_r[i] <= '0;
      end
      cur_r <= '0;
      idx_r <= '0;
      cnt_r <= '0;
      slice_cnt_r <= '0;
      slice_len_r <= 8'd10;
      en_r <= 1'b0;
      next_id_r <= 32'd2;
      now_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cfg_we) begin
        if (cfg_index == rrts_pkg::CFG_SLICE) slice_len_r <= cfg_data;
        else en_r <= cfg_data[0];
      end
      if (cmd.scan_init) begin
        idx_r <= '0;
        cnt_r <= '0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.latch) begin
        sp_in_r <= in_stack_pointer;
        out_switched <= 1'b0;
        out_resume_pointer <= in_stack_pointer;
        out_thread_id <= '0;
        out_status <= lat_status;
        case (op)
          rrts_pkg::OP_TICK: begin
            now_r <= now_r + 64'd1;
            if (en_r) slice_cnt_r <= slice_inc;
          end
          rrts_pkg::OP_KILL: begin
            if (live) begin
              st_r[tslot] <= rrts_pkg::ST_DEAD;
              id_r[tslot] <= '0;
            end
          end
          rrts_pkg::OP_SLEEP: begin
            if (en_r && live) begin
              st_r[tslot] <= rrts_pkg::ST_SLEEPING;
              wake_r[tslot] <= now_r + {32'd0, in_sleep_ticks};
            end
          end
          default: ;
        endcase
      end
      if (cmd.create_step && sts.found) begin
        st_r[idx_r] <= rrts_pkg::ST_READY;
        sp_r[idx_r] <= sp_in_r;
        wake_r[idx_r] <= '0;
        id_r[idx_r] <= next_id_r;
        out_thread_id <= next_id_r;
        out_status <= 1'b0;
        next_id_r <= next_id_inc;
      end
      if (cmd.prep) begin
        sp_r[cur_r] <= sp_in_r;
        if (st_r[cur_r] == rrts_pkg::ST_RUNNING) st_r[cur_r] <= rrts_pkg::ST_READY;
      end
      if (cmd.wake_step && st_r[idx_r] == rrts_pkg::ST_SLEEPING && wake_r[idx_r] <= now_r)
        st_r[idx_r] <= rrts_pkg::ST_READY;
      if (cmd.finish) begin
        // no ready slot: stay on current
        st_r[sts.found ? cand : cur_r] <= rrts_pkg::ST_RUNNING;
        cur_r <= sts.found ? cand : cur_r;
        out_resume_pointer <= sts.found ? sp_r[cand] : sp_r[cur_r];
        slice_cnt_r <= '0;
      end
      if (cmd.set_sw) out_switched <= 1'b1;
    end
  end

  always_comb begin
    out_running_slot = 4'(cur_r);
  end
endmodule
`default_nettype wire
